/* rtl/core/spq_pkg.sv */
// Package: types and constants shared by the sorted priority queue files.
package spq_pkg;

  localparam int unsigned QueueDepth = 16;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeRemove = 1'b1;

  typedef struct packed {
    logic [15:0] item;
    logic [15:0] prio;
  } spq_entry_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] entry_item;
    logic [15:0] entry_priority;
  } spq_in_t;

  typedef struct packed {
    logic [15:0] out_item;
    logic [15:0] out_priority;
    logic        out_valid;
    logic        overflow;
    logic        now_empty;
  } spq_out_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic       ins;
    logic       rem;
    spq_entry_t new_entry;
  } spq_ctrl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic       valid;
    logic       displaced;
    spq_entry_t entry;
  } spq_link_t;

endpackage

/* rtl/core/spq_cell.sv */
// One storage cell of the sorted queue row.
module spq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_pkg::spq_ctrl_t ctrl_i,
  input  spq_pkg::spq_link_t left_i,
  input  spq_pkg::spq_link_t right_i,
  output spq_pkg::spq_link_t link_o
);

  logic                valid_q, valid_d;
  spq_pkg::spq_entry_t entry_q, entry_d;
  logic                displaced;

  // Cells are a sorted prefix, so displaced is monotonic along the row.
  assign displaced = !valid_q || (entry_q.prio >= ctrl_i.new_entry.prio);

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (displaced) begin
        entry_d = left_i.displaced ? left_i.entry : ctrl_i.new_entry;
        valid_d = valid_q | left_i.valid;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i.entry;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o.valid     = valid_q;
  assign link_o.displaced = displaced;
  assign link_o.entry     = entry_q;

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Top level: sorted priority queue built as a row of compare-and-shift cells.
// On an accepted transaction (insert or remove-minimum) all cells compare
// against the new priority and shift one place toward or away from the
// head at once. The result is shown on out_o with out_strobe_o high for the
// next cycle, during which busy is high, so no new transaction is taken while
// a result is shown. The receiver cannot stall; it must take the result in
// that cycle. Inserting into a full queue drops the entry and reports overflow.
module sorted_priority_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::spq_in_t  in_i,
  output spq_pkg::spq_out_t out_o,
  output logic             out_strobe_o
);

  localparam int unsigned Depth = spq_pkg::QueueDepth;

  spq_pkg::spq_link_t links [Depth];
  spq_pkg::spq_ctrl_t ctrl;
  spq_pkg::spq_out_t  out_q, out_d;
  logic               strobe_q;
  logic               accept;
  logic               full, empty;

  assign accept = start && !busy;
  assign full   = links[Depth-1].valid;
  assign empty  = !links[0].valid;

  always_comb begin
    ctrl.ins            = accept && (in_i.mode == spq_pkg::ModeInsert) && !full;
    ctrl.rem            = accept && (in_i.mode == spq_pkg::ModeRemove);
    ctrl.new_entry.item = in_i.entry_item;
    ctrl.new_entry.prio = in_i.entry_priority;
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    spq_pkg::spq_link_t left, right;
    if (i == 0) begin : g_head
      assign left = '{valid: 1'b1, displaced: 1'b0, entry: '0};
    end else begin : g_mid
      assign left = links[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = links[i+1];
    end
    spq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (links[i])
    );
  end

  always_comb begin
    out_d = '0;
    if (in_i.mode == spq_pkg::ModeInsert) begin
      out_d.overflow = full;
    end else if (!empty) begin
      out_d.out_item     = links[0].entry.item;
      out_d.out_priority = links[0].entry.prio;
      out_d.out_valid    = 1'b1;
    end
    // After a remove, the old second cell becomes the head.
    out_d.now_empty = (in_i.mode == spq_pkg::ModeRemove) && !links[1].valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign busy         = strobe_q;
  assign out_o        = out_q;
  assign out_strobe_o = strobe_q;

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input spq_pkg::spq_out_t out_o,
  input logic             out_strobe_o
);

  // Every accepted transaction gives a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> out_strobe_o)
    else $error("no result after accepted transaction");

  // No result without an accepted transaction.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(start && !busy))
    else $error("result without transaction");

  a_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> !(out_o.out_valid && out_o.overflow))
    else $error("removed entry and overflow together");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && !out_o.out_valid |->
      (out_o.out_item == 16'd0) && (out_o.out_priority == 16'd0))
    else $error("payload nonzero without removed entry");

  // A full queue cannot be empty.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o && out_o.overflow |-> !out_o.now_empty)
    else $error("overflow reported with empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .out_o        (out_o),
  .out_strobe_o (out_strobe_o)
);
